// ===== hw/rtl/stftm_pkg.sv =====
// ----------------------------------------------------------------------------
// stftm_pkg
// Shared types, sizes and constant tables for the windowed STFT magnitude core.
// ----------------------------------------------------------------------------
package stftm_pkg;

	// Transform size and derived sizes
	localparam int NFFT   = 64;
	localparam int LOG_N  = $clog2(NFFT);
	localparam int HOP    = NFFT / 2;
	localparam int NBINS  = NFFT / 2 + 1;
	localparam int STG_W  = $clog2(LOG_N);
	localparam int CNT_W  = LOG_N + 1;

	// Field and datapath widths
	localparam int SMP_W  = 16;
	localparam int FRM_W  = 16;
	localparam int BIN_W  = 6;
	localparam int MAG_W  = 23;
	localparam int WRK_W  = 23;
	localparam int TW_W   = 32;
	localparam int ROOT_W = 24;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int RST_W  = $clog2(ROOT_W);

	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	// Q2.30 angle constants for the table generator
	localparam longint Q30_HALF_PI = 64'sd1686629713;
	localparam longint Q30_PI      = 2 * Q30_HALF_PI;
	localparam longint CORDIC_GAIN = 64'sd652032874;
	localparam int     CORDIC_N    = 31;

	localparam longint ATAN_Q30 [CORDIC_N] = '{
		64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
		64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
		64'sd4194283, 64'sd2097149, 64'sd1048575, 64'sd524288, 64'sd262144,
		64'sd131072, 64'sd65536, 64'sd32768, 64'sd16384, 64'sd8192,
		64'sd4096, 64'sd2048, 64'sd1024, 64'sd512, 64'sd256, 64'sd128,
		64'sd64, 64'sd32, 64'sd16, 64'sd8, 64'sd4, 64'sd2, 64'sd1
	};

	// Back end sequencer
	typedef enum logic [3:0] {
		B_IDLE,
		B_LOAD,
		B_BF_RD,
		B_BF_MUL,
		B_BF_ADD,
		B_BF_WA,
		B_BF_WB,
		B_MAG_RD,
		B_MAG_SQ,
		B_MAG_SUM,
		B_MAG_ROOT,
		B_MAG_OUT,
		B_NONE
	} back_state_t;

	// One unit of work handed from front to back
	typedef struct packed {
		logic             none;
		logic [FRM_W-1:0] frame;
		logic [CNT_W-1:0] count;
	} job_t;

	// Sample ring read request from the back end
	typedef struct packed {
		logic             loading;
		logic [LOG_N-1:0] addr;
	} ring_req_t;

	typedef logic [15:0]             win_tab_t [NFFT];
	typedef logic signed [TW_W-1:0]  tw_tab_t  [NFFT/2];

	// CORDIC cos/sin for an angle in [0, pi], Q2.30
	function automatic longint trig(input longint th, input bit want_sin);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		bit     flip;
		int     k;
		flip = th > Q30_HALF_PI;
		z = flip ? (Q30_PI - th) : th;
		x = CORDIC_GAIN;
		y = 0;
		for (k = 0; k < CORDIC_N; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_Q30[k];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_Q30[k];
			end
		end
		return want_sin ? y : (flip ? -x : x);
	endfunction

	// Hamming window, unsigned Q1.15
	function automatic win_tab_t make_win();
		win_tab_t w;
		longint   m;
		longint   c;
		longint   v;
		int       i;
		for (i = 0; i < NFFT; i++) begin
			m = (i <= NFFT - 1 - i) ? i : NFFT - 1 - i;
			c = trig((2 * Q30_PI * m) / (NFFT - 1), 1'b0);
			v = (54 * (64'sd1 << 30) - 46 * c + 50 * 32768) / (100 * 32768);
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			w[i] = v[15:0];
		end
		return w;
	endfunction

	// Twiddle table, cos or sin of 2*pi*k/NFFT
	function automatic tw_tab_t make_tw(input bit want_sin);
		tw_tab_t t;
		longint  v;
		int      k;
		for (k = 0; k < NFFT / 2; k++) begin
			v = trig((2 * Q30_PI * k) / NFFT, want_sin);
			t[k] = v[TW_W-1:0];
		end
		return t;
	endfunction

	localparam win_tab_t WIN_ROM = make_win();
	localparam tw_tab_t  TW_COS  = make_tw(1'b0);
	localparam tw_tab_t  TW_SIN  = make_tw(1'b1);

	function automatic logic [LOG_N-1:0] bit_rev(input logic [LOG_N-1:0] v);
		logic [LOG_N-1:0] r;
		for (int b = 0; b < LOG_N; b++)
			r[b] = v[LOG_N-1-b];
		return r;
	endfunction

endpackage

// ===== hw/rtl/stftm_front.sv =====
// ----------------------------------------------------------------------------
// stftm_front
// Accepts sample and flush words, keeps the sample ring and record counters,
// and turns each completed or flushed frame into a job for the back end.
// ----------------------------------------------------------------------------
module stftm_front import stftm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    action,
	input  logic signed [SMP_W-1:0] diff_sample,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [FRM_W-1:0]        cfg_data,
	output logic                    job_push,
	output job_t                    job_out,
	input  logic                    q_empty,
	input  ring_req_t               ring_req,
	output logic signed [SMP_W-1:0] ring_data
);

	logic signed [SMP_W-1:0] ring_mem [NFFT];
	logic signed [SMP_W-1:0] ring_rd_q;

	logic [31:0]      seen_q;
	logic [FRM_W-1:0] done_q;
	logic [FRM_W-1:0] limit_q;
	logic             ended_q;

	logic                accept;
	logic                smp_ok;
	logic [31:0]         n1;
	logic                frm_edge;
	logic [31:0]         j;
	logic                j_ok;
	logic [31:0]         first;
	logic [31:0]         p;
	logic [32+LOG_N-2:0] p_start;
	logic [32+LOG_N-2:0] seen_ext;
	logic                p_ok;
	logic                take_smp;
	logic                frm_emit;

	// Ring must not be overwritten until the back end has copied the frame
	assign in_stall  = !q_empty || ring_req.loading;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign ring_data = ring_rd_q;

	// Sample word: frame completion test
	assign smp_ok   = !ended_q && (seen_q != '1);
	assign take_smp = accept && !action && smp_ok;
	assign n1       = seen_q + 32'd1;
	assign frm_edge = (n1 >= 32'(NFFT)) && (n1[LOG_N-2:0] == '0);
	assign j        = (n1 - 32'(NFFT)) >> (LOG_N - 1);
	assign j_ok     = j < {16'd0, limit_q};
	assign frm_emit = take_smp && frm_edge && j_ok;

	// Flush word: oldest frame still pending
	assign first    = (seen_q < 32'(NFFT)) ? 32'd0
	                : ((seen_q - 32'(NFFT)) >> (LOG_N - 1)) + 32'd1;
	assign p        = ({16'd0, done_q} > first) ? {16'd0, done_q} : first;
	assign p_start  = {p, {(LOG_N-1){1'b0}}};
	assign seen_ext = (32+LOG_N-1)'(seen_q);
	assign p_ok     = (p < {16'd0, limit_q}) && (p_start < seen_ext);

	// Job selection
	always_comb begin
		job_push = 1'b0;
		job_out  = '0;
		if (frm_emit) begin
			job_push       = 1'b1;
			job_out.frame  = j[FRM_W-1:0];
			job_out.count  = CNT_W'(NFFT);
		end else if (accept && action) begin
			job_push = 1'b1;
			if (p_ok) begin
				job_out.frame = p[FRM_W-1:0];
				job_out.count = CNT_W'(seen_ext - p_start);
			end else begin
				job_out.none  = 1'b1;
			end
		end
	end

	// Record counters and frame limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			done_q  <= '0;
			ended_q <= 1'b0;
			limit_q <= '1;
		end else begin
			if (cfg_valid && cfg_ready)
				limit_q <= cfg_data;
			if (take_smp)
				seen_q <= n1;
			if (frm_emit)
				done_q <= j[FRM_W-1:0] + FRM_W'(1);
			if (accept && action) begin
				ended_q <= 1'b1;
				if (p_ok)
					done_q <= p[FRM_W-1:0] + FRM_W'(1);
			end
		end
	end

	// Sample ring, one write and one registered read
	always_ff @(posedge clk) begin
		if (take_smp)
			ring_mem[seen_q[LOG_N-1:0]] <= diff_sample;
		ring_rd_q <= ring_mem[ring_req.addr];
	end

endmodule

// ===== hw/rtl/stftm_jobq.sv =====
// ----------------------------------------------------------------------------
// stftm_jobq
// Two-entry job queue between the front and the back end.
// ----------------------------------------------------------------------------
module stftm_jobq import stftm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic head_valid,
	output logic empty
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign empty      = (fill_q == 2'd0);
	assign head_valid = !empty;
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && (fill_q != 2'd2);
	assign do_pop     = pop && !empty;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_job;
	end

endmodule

// ===== hw/rtl/stftm_back.sv =====
// ----------------------------------------------------------------------------
// stftm_back
// Runs one job: windowed copy from the ring, in-place radix-2 FFT on a shared
// butterfly, then a bit-serial square root per bin into the output register.
// ----------------------------------------------------------------------------
module stftm_back import stftm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  job_t                    job,
	input  logic                    job_valid,
	output logic                    job_pop,
	output ring_req_t               ring_req,
	input  logic signed [SMP_W-1:0] ring_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [FRM_W-1:0]        frame_index,
	output logic [BIN_W-1:0]        bin_index,
	output logic [MAG_W-1:0]        magnitude,
	output logic                    last_bin,
	output logic                    none_pending
);

	back_state_t state_q, state_d;
	job_t        job_q;

	// Work memory: {re, im}
	logic [2*WRK_W-1:0] work_mem [NFFT];
	logic [2*WRK_W-1:0] rd0_q, rd1_q;
	logic [LOG_N-1:0]   raddr0, raddr1, waddr;
	logic [2*WRK_W-1:0] wdata;
	logic               mem_we;

	// Load pipeline
	logic [CNT_W-1:0] ld_cnt_q;
	logic             ld_v_s1;
	logic [LOG_N-1:0] ld_idx_s1;
	logic             ld_issue;

	// Butterfly sequencing
	logic [STG_W-1:0] stg_q;
	logic [LOG_N-2:0] bfq_q;
	logic [LOG_N-1:0] q_ext, half, mask, a_addr, b_addr;
	logic [LOG_N-2:0] tw_idx;
	logic             bf_last;

	logic signed [TW_W-1:0]        c_q, s_q;
	logic signed [WRK_W-1:0]       a_re_q, a_im_q, br, bi;
	logic signed [WRK_W+TW_W-1:0]  p_rc_q, p_is_q, p_ic_q, p_rs_q;
	logic signed [WRK_W+TW_W:0]    sum_r, sum_i;
	logic signed [WRK_W-1:0]       t_re_q, t_im_q;

	// Windowing
	logic signed [SMP_W-1:0] smp;
	logic signed [SMP_W:0]   win_s;
	logic signed [2*SMP_W:0] prod;
	logic signed [2*SMP_W+1:0] rsum;
	logic signed [2*SMP_W+1:0] y_wide;
	logic signed [SMP_W-1:0] y16;

	// Magnitude
	logic [LOG_N-1:0]          bin_q;
	logic signed [WRK_W-1:0]   m_re, m_im;
	logic signed [2*WRK_W-1:0] sq_re_q, sq_im_q;
	logic [RAD_W-1:0]          rad_q;
	logic [ROOT_W-1:0]         root_q;
	logic [ROOT_W+1:0]         rem_q, rem_sh, trial;
	logic [RST_W-1:0]          rstep_q;
	logic                      root_done;

	// Output register
	logic             out_v_q;
	logic [FRM_W-1:0] frame_q;
	logic [BIN_W-1:0] bin_out_q;
	logic [MAG_W-1:0] mag_q;
	logic             last_q;
	logic             none_q;
	logic             out_free;
	logic             out_load;

	assign out_free     = !out_v_q || !out_stall;
	assign out_valid    = out_v_q;
	assign frame_index  = frame_q;
	assign bin_index    = bin_out_q;
	assign magnitude    = mag_q;
	assign last_bin     = last_q;
	assign none_pending = none_q;

	// Butterfly addressing for stage stg_q, butterfly bfq_q
	assign q_ext   = {1'b0, bfq_q};
	assign half    = LOG_N'(1) << stg_q;
	assign mask    = half - LOG_N'(1);
	assign a_addr  = ((q_ext >> stg_q) << (stg_q + 1)) | (q_ext & mask);
	assign b_addr  = a_addr | half;
	assign tw_idx  = (LOG_N-1)'((q_ext & mask) << (LOG_N - 1 - stg_q));
	assign bf_last = (bfq_q == '1) && (stg_q == STG_W'(LOG_N - 1));

	assign br   = rd1_q[2*WRK_W-1:WRK_W];
	assign bi   = rd1_q[WRK_W-1:0];
	assign m_re = rd0_q[2*WRK_W-1:WRK_W];
	assign m_im = rd0_q[WRK_W-1:0];

	assign sum_r = (WRK_W+TW_W+1)'(p_rc_q) + (WRK_W+TW_W+1)'(p_is_q)
	             + (WRK_W+TW_W+1)'(64'sd536870912);
	assign sum_i = (WRK_W+TW_W+1)'(p_ic_q) - (WRK_W+TW_W+1)'(p_rs_q)
	             + (WRK_W+TW_W+1)'(64'sd536870912);

	// Windowed sample for the load write
	assign smp    = ({1'b0, ld_idx_s1} < job_q.count) ? ring_data : '0;
	assign win_s  = $signed({1'b0, WIN_ROM[ld_idx_s1]});
	assign prod   = smp * win_s;
	assign rsum   = (2*SMP_W+2)'(prod) + (2*SMP_W+2)'(32'sd16384);
	assign y_wide = rsum >>> 15;
	always_comb begin
		if (y_wide > (2*SMP_W+2)'(32'sd32767))
			y16 = 16'sh7fff;
		else if (y_wide < (2*SMP_W+2)'(-32'sd32768))
			y16 = 16'sh8000;
		else
			y16 = y_wide[SMP_W-1:0];
	end

	// Square root step
	assign rem_sh    = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1:RAD_W-2]};
	assign trial     = {root_q, 2'b01};
	assign root_done = (rstep_q == RST_W'(ROOT_W - 1));

	assign ld_issue = (state_q == B_LOAD) && (ld_cnt_q != CNT_W'(NFFT));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:     if (job_valid) state_d = job.none ? B_NONE : B_LOAD;
			B_LOAD:     if (ld_cnt_q == CNT_W'(NFFT)) state_d = B_BF_RD;
			B_BF_RD:    state_d = B_BF_MUL;
			B_BF_MUL:   state_d = B_BF_ADD;
			B_BF_ADD:   state_d = B_BF_WA;
			B_BF_WA:    state_d = B_BF_WB;
			B_BF_WB:    state_d = bf_last ? B_MAG_RD : B_BF_RD;
			B_MAG_RD:   state_d = B_MAG_SQ;
			B_MAG_SQ:   state_d = B_MAG_SUM;
			B_MAG_SUM:  state_d = B_MAG_ROOT;
			B_MAG_ROOT: if (root_done) state_d = B_MAG_OUT;
			B_MAG_OUT: begin
				if (out_free)
					state_d = (bin_q == LOG_N'(NBINS - 1)) ? B_IDLE : B_MAG_RD;
			end
			B_NONE:     if (out_free) state_d = B_IDLE;
			default:    state_d = B_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		job_pop          = 1'b0;
		ring_req.loading = 1'b0;
		ring_req.addr    = {job_q.frame[0], {(LOG_N-1){1'b0}}} + ld_cnt_q[LOG_N-1:0];
		mem_we           = 1'b0;
		waddr            = a_addr;
		wdata            = {a_re_q + t_re_q, a_im_q + t_im_q};
		raddr0           = a_addr;
		raddr1           = b_addr;
		out_load         = 1'b0;
		unique case (state_q)
			B_IDLE:  job_pop = job_valid;
			B_LOAD: begin
				ring_req.loading = 1'b1;
				mem_we = ld_v_s1;
				waddr  = bit_rev(ld_idx_s1);
				wdata  = {WRK_W'(y16), WRK_W'(0)};
			end
			B_BF_WA: mem_we = 1'b1;
			B_BF_WB: begin
				mem_we = 1'b1;
				waddr  = b_addr;
				wdata  = {a_re_q - t_re_q, a_im_q - t_im_q};
			end
			B_MAG_RD:  raddr0 = bin_q;
			B_MAG_OUT: out_load = out_free;
			B_NONE:    out_load = out_free;
			default: begin
			end
		endcase
	end

	// Sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			ld_cnt_q <= '0;
			ld_v_s1  <= 1'b0;
			stg_q    <= '0;
			bfq_q    <= '0;
			bin_q    <= '0;
			rstep_q  <= '0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ld_v_s1 <= ld_issue;
			if (job_pop) begin
				ld_cnt_q <= '0;
				stg_q    <= '0;
				bfq_q    <= '0;
				bin_q    <= '0;
			end
			if (ld_issue)
				ld_cnt_q <= ld_cnt_q + CNT_W'(1);
			if (state_q == B_BF_WB) begin
				bfq_q <= bfq_q + (LOG_N-1)'(1);
				if (bfq_q == '1)
					stg_q <= stg_q + STG_W'(1);
			end
			if (state_q == B_MAG_SUM)
				rstep_q <= '0;
			else if (state_q == B_MAG_ROOT)
				rstep_q <= rstep_q + RST_W'(1);
			if (out_load && state_q == B_MAG_OUT)
				bin_q <= bin_q + LOG_N'(1);
			if (out_load)
				out_v_q <= 1'b1;
			else if (!out_stall)
				out_v_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		ld_idx_s1 <= ld_cnt_q[LOG_N-1:0];
		if (job_pop)
			job_q <= job;
		if (state_q == B_BF_RD) begin
			c_q <= TW_COS[tw_idx];
			s_q <= TW_SIN[tw_idx];
		end
		if (state_q == B_BF_MUL) begin
			a_re_q <= rd0_q[2*WRK_W-1:WRK_W];
			a_im_q <= rd0_q[WRK_W-1:0];
			p_rc_q <= br * c_q;
			p_is_q <= bi * s_q;
			p_ic_q <= bi * c_q;
			p_rs_q <= br * s_q;
		end
		if (state_q == B_BF_ADD) begin
			t_re_q <= WRK_W'(sum_r >>> 30);
			t_im_q <= WRK_W'(sum_i >>> 30);
		end
		if (state_q == B_MAG_SQ) begin
			sq_re_q <= m_re * m_re;
			sq_im_q <= m_im * m_im;
		end
		if (state_q == B_MAG_SUM) begin
			rad_q  <= RAD_W'($unsigned(sq_re_q)) + RAD_W'($unsigned(sq_im_q));
			root_q <= '0;
			rem_q  <= '0;
		end
		if (state_q == B_MAG_ROOT) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (out_load) begin
			if (state_q == B_NONE) begin
				frame_q   <= '0;
				bin_out_q <= '0;
				mag_q     <= '0;
				last_q    <= 1'b0;
				none_q    <= 1'b1;
			end else begin
				frame_q   <= job_q.frame;
				bin_out_q <= BIN_W'(bin_q);
				mag_q     <= (root_q > ROOT_W'(MAG_MAX)) ? MAG_MAX : root_q[MAG_W-1:0];
				last_q    <= (bin_q == LOG_N'(NBINS - 1));
				none_q    <= 1'b0;
			end
		end
	end

	// Work memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (mem_we)
			work_mem[waddr] <= wdata;
		rd0_q <= work_mem[raddr0];
		rd1_q <= work_mem[raddr1];
	end

endmodule

// ===== hw/rtl/windowed_stft_magnitude_core.sv =====
// ----------------------------------------------------------------------------
// windowed_stft_magnitude_core
// Hamming-windowed short-time FFT magnitude of a signed 16-bit sample stream.
// ----------------------------------------------------------------------------
// Samples are cut into 64-sample frames with a hop of 32; each completed frame
// below frame_limit yields 33 words, one magnitude per bin 0..32, and a flush
// word zero-pads and emits the oldest pending frame or one none_pending word.
// Input: a sample word is accepted while the back end is busy on the FFT or root
// phases. Each frame is a windowed copy from the ring, then every butterfly on the
// single shared butterfly, each through read, multiply, add, write-A and write-B
// states, then a bit-serial square root per bin; in_stall is high during the
// ring copy and while a finished frame waits for the back end. The output register
// lets the next word be computed while the current one is held by out_stall.
module windowed_stft_magnitude_core import stftm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    action,
	input  logic signed [SMP_W-1:0] diff_sample,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [FRM_W-1:0]        cfg_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [FRM_W-1:0]        frame_index,
	output logic [BIN_W-1:0]        bin_index,
	output logic [MAG_W-1:0]        magnitude,
	output logic                    last_bin,
	output logic                    none_pending
);

	job_t                    push_job, head_job;
	logic                    job_push, job_pop, head_valid, q_empty;
	ring_req_t               ring_req;
	logic signed [SMP_W-1:0] ring_data;

	stftm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.diff_sample (diff_sample),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.job_push    (job_push),
		.job_out     (push_job),
		.q_empty     (q_empty),
		.ring_req    (ring_req),
		.ring_data   (ring_data)
	);

	stftm_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (push_job),
		.pop        (job_pop),
		.head       (head_job),
		.head_valid (head_valid),
		.empty      (q_empty)
	);

	stftm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (head_job),
		.job_valid    (head_valid),
		.job_pop      (job_pop),
		.ring_req     (ring_req),
		.ring_data    (ring_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_index  (frame_index),
		.bin_index    (bin_index),
		.magnitude    (magnitude),
		.last_bin     (last_bin),
		.none_pending (none_pending)
	);

endmodule

// ===== hw/rtl/stftm_chk.sv =====
// ----------------------------------------------------------------------------
// stftm_chk
// Port-level checks on the result stream of the STFT magnitude core.
// ----------------------------------------------------------------------------
module stftm_chk import stftm_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [FRM_W-1:0]        frame_index,
	input logic [BIN_W-1:0]        bin_index,
	input logic [MAG_W-1:0]        magnitude,
	input logic                    last_bin,
	input logic                    none_pending
);

	// A held word keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid
			&& $stable({frame_index, bin_index, magnitude, last_bin, none_pending}))
		else $error("result word changed while stalled");

	// An empty flush word carries nothing else
	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && none_pending |-> frame_index == '0 && bin_index == '0
			&& magnitude == '0 && !last_bin)
		else $error("none_pending word with nonzero fields");

	// Last bin flag marks exactly the top bin
	a_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !none_pending |->
			last_bin == (bin_index == BIN_W'(NBINS - 1)))
		else $error("last_bin disagrees with bin_index");

	// Bins of a frame come in rising order
	a_bin_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !none_pending && !last_bin ##1 out_valid
			|-> bin_index == $past(bin_index) + BIN_W'(1)
				&& frame_index == $past(frame_index))
		else $error("bin sequence broken within a frame");

endmodule

bind windowed_stft_magnitude_core stftm_chk u_stftm_chk (.*);
